@@ hdl/epb_pkg.sv @@
`default_nettype none
package epb_pkg;

  localparam int unsigned MAX_CAPTURE = 262144;

  localparam int CAP_W  = 19;   // capture length after the limit check
  localparam int BLEN_W = 19;   // block total length
  localparam int TS_W   = 53;   // seconds * 1e6 + fraction
  localparam int Q_W    = 30;   // fraction after optional divide
  localparam int MUL_W  = 52;   // seconds * 1e6
  localparam int STEP_W = 4;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = 3;
  localparam int QCNT_W = 4;

  localparam int ADDR_W = 5;

  // configuration register indexes (paddr[4:2])
  localparam logic [2:0] REG_GPS_ENABLE   = 3'd0;
  localparam logic [2:0] REG_NANO_MODE    = 3'd1;
  localparam logic [2:0] REG_LONGITUDE_E7 = 3'd2;
  localparam logic [2:0] REG_LATITUDE_E7  = 3'd3;
  localparam logic [2:0] REG_ALTITUDE_E4  = 3'd4;

  localparam logic OP_HDR  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam logic [31:0] EPB_TYPE  = 32'h0000_0006;
  localparam logic [15:0] OPT_CUSTOM = 16'd2989;
  localparam logic [31:0] GPS_PEN   = 32'd55922;
  localparam logic [7:0]  MAGIC_TAG = 8'h47;
  localparam logic [7:0]  GPS_VER   = 8'h01;
  localparam logic [31:0] MASK_LON  = 32'h0000_0002;
  localparam logic [31:0] MASK_LAT  = 32'h0000_0004;
  localparam logic [31:0] MASK_ALT  = 32'h0000_0008;

  localparam logic signed [31:0] COORD_MAX  = 32'sd1800000000;
  localparam logic signed [31:0] COORD_MIN  = -32'sd1800000000;
  localparam logic [31:0]        COORD_SPAN = 32'd3600000000;

  localparam int EPB_FIXED       = 32;  // header words plus trailing length
  localparam int OPT_LEN_GPS     = 28;
  localparam int OPT_LEN_GPS_ALT = 32;

  localparam logic [19:0] US_PER_S  = 20'd1000000;
  // floor(x / 1000) == (x * DIV_MAGIC) >> 40 for any 30-bit x
  localparam logic [30:0] DIV_MAGIC = 31'd1099511628;

  // header word steps
  localparam logic [STEP_W-1:0] HS_TYPE  = 4'd0;
  localparam logic [STEP_W-1:0] HS_BLEN  = 4'd1;
  localparam logic [STEP_W-1:0] HS_IFACE = 4'd2;
  localparam logic [STEP_W-1:0] HS_TS_HI = 4'd3;
  localparam logic [STEP_W-1:0] HS_TS_LO = 4'd4;
  localparam logic [STEP_W-1:0] HS_CAP   = 4'd5;
  localparam logic [STEP_W-1:0] HS_ORIG  = 4'd6;

  // trailer word steps
  localparam logic [STEP_W-1:0] TS_OPT      = 4'd0;
  localparam logic [STEP_W-1:0] TS_PEN      = 4'd1;
  localparam logic [STEP_W-1:0] TS_MAGIC    = 4'd2;
  localparam logic [STEP_W-1:0] TS_MASK     = 4'd3;
  localparam logic [STEP_W-1:0] TS_LON      = 4'd4;
  localparam logic [STEP_W-1:0] TS_LAT      = 4'd5;
  localparam logic [STEP_W-1:0] TS_ALT      = 4'd6;
  localparam logic [STEP_W-1:0] TS_LAST_GPS = 4'd7;
  localparam logic [STEP_W-1:0] TS_LAST_ALT = 4'd8;

  typedef struct packed {
    logic        op;
    logic [31:0] ts_seconds;
    logic [29:0] ts_fraction;
    logic [31:0] capture_length;
    logic [31:0] original_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        error;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_WORD,
    CMD_ERR
  } cmd_kind_t;

  typedef enum logic [1:0] {
    OPT_NONE,
    OPT_GPS,
    OPT_GPS_ALT
  } opt_shape_t;

  typedef enum logic {
    PH_CMD,
    PH_TRAIL
  } back_phase_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              trail;
    logic [31:0]       data;
    logic [31:0]       orig;
    logic [BLEN_W-1:0] blen;
    opt_shape_t        shape;
    logic [TS_W-1:0]   ts;
  } cmd_t;

  typedef struct packed {
    logic gps_enable;
    logic nano_mode;
    logic alt_present;
  } front_cfg_t;

  typedef struct packed {
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [31:0] altitude;
  } pos_t;

endpackage
`default_nettype wire

@@ hdl/epb_front.sv @@
`default_nettype none
module epb_front import epb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  in_item_t          capture,
  input  front_cfg_t        cfg,
  input  logic [QCNT_W-1:0] q_count,
  output logic              cmd_push,
  output cmd_t              cmd
);

  logic              in_packet, in_packet_next;
  logic [CAP_W-1:0]  bytes_left, bytes_left_next;
  logic [23:0]       partial_word, partial_word_next;
  logic [1:0]        byte_lane, byte_lane_next;

  logic              s0_valid, s1_valid, s2_valid;
  cmd_t              s0_cmd, s1_cmd, s2_cmd;
  cmd_t              s1_done;
  logic [31:0]       s0_secs;
  logic [Q_W-1:0]    s0_q, s1_q;
  logic [MUL_W-1:0]  s1_mul;

  logic              accept;
  logic [1:0]        inflight;
  logic              new_valid;
  cmd_t              new_cmd;
  logic [Q_W-1:0]    new_q;
  logic [60:0]       frac_prod;
  logic              cap_ok;
  logic [CAP_W-1:0]  cap19;
  logic [1:0]        pad;
  opt_shape_t        shape;
  logic [5:0]        opt_len;
  logic [31:0]       packed_word;
  logic [CAP_W-1:0]  left_dec;

  // credit: every item in the pipe may turn into one queue entry
  assign inflight = 2'(s0_valid) + 2'(s1_valid) + 2'(s2_valid);
  assign full     = ({1'b0, q_count} + (QCNT_W+1)'(inflight)) >= (QCNT_W+1)'(QDEPTH);
  assign accept   = push && !full;

  assign frac_prod = 61'(capture.ts_fraction) * 61'(DIV_MAGIC);
  assign new_q     = cfg.nano_mode ? Q_W'(frac_prod[60:40]) : capture.ts_fraction;

  assign cap_ok = capture.capture_length <= 32'(MAX_CAPTURE);
  assign cap19  = capture.capture_length[CAP_W-1:0];
  assign pad    = 2'd0 - cap19[1:0];

  always_comb begin
    if (!cfg.gps_enable) begin
      shape   = OPT_NONE;
      opt_len = 6'd0;
    end else if (cfg.alt_present) begin
      shape   = OPT_GPS_ALT;
      opt_len = 6'(OPT_LEN_GPS_ALT);
    end else begin
      shape   = OPT_GPS;
      opt_len = 6'(OPT_LEN_GPS);
    end
  end

  assign packed_word = {8'h00, partial_word} | (32'(capture.data_byte) << {byte_lane, 3'b000});
  assign left_dec    = bytes_left - CAP_W'(1);

  always_comb begin
    in_packet_next    = in_packet;
    bytes_left_next   = bytes_left;
    partial_word_next = partial_word;
    byte_lane_next    = byte_lane;
    new_valid         = 1'b0;
    new_cmd           = '0;
    if (accept) begin
      if (capture.op == OP_HDR) begin
        in_packet_next    = 1'b0;
        bytes_left_next   = '0;
        partial_word_next = '0;
        byte_lane_next    = '0;
        new_valid         = 1'b1;
        if (!cap_ok) begin
          new_cmd.kind = CMD_ERR;
        end else begin
          new_cmd.kind  = CMD_HDR;
          new_cmd.data  = capture.capture_length;
          new_cmd.orig  = capture.original_length;
          new_cmd.shape = shape;
          new_cmd.blen  = BLEN_W'(EPB_FIXED) + cap19 + BLEN_W'(pad) + BLEN_W'(opt_len);
          new_cmd.trail = (cap19 == '0);
          if (cap19 != '0) begin
            in_packet_next  = 1'b1;
            bytes_left_next = cap19;
          end
        end
      end else if (in_packet && bytes_left != '0) begin
        bytes_left_next = left_dec;
        if (byte_lane == 2'd3 || left_dec == '0) begin
          new_valid         = 1'b1;
          new_cmd.kind      = CMD_WORD;
          new_cmd.data      = packed_word;
          new_cmd.trail     = (left_dec == '0);
          partial_word_next = '0;
          byte_lane_next    = '0;
          if (left_dec == '0) begin
            in_packet_next = 1'b0;
          end
        end else begin
          partial_word_next = packed_word[23:0];
          byte_lane_next    = byte_lane + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet    <= 1'b0;
      bytes_left   <= '0;
      partial_word <= '0;
      byte_lane    <= '0;
      s0_valid     <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
    end else begin
      in_packet    <= in_packet_next;
      bytes_left   <= bytes_left_next;
      partial_word <= partial_word_next;
      byte_lane    <= byte_lane_next;
      s0_valid     <= new_valid;
      s1_valid     <= s0_valid;
      s2_valid     <= s1_valid;
    end
  end

  always_comb begin
    s1_done    = s1_cmd;
    s1_done.ts = TS_W'(s1_mul) + TS_W'(s1_q);
  end

  // timestamp pipe: divide, scale seconds, add
  always_ff @(posedge clk) begin
    s0_cmd  <= new_cmd;
    s0_secs <= capture.ts_seconds;
    s0_q    <= new_q;
    s1_cmd  <= s0_cmd;
    s1_mul  <= MUL_W'(s0_secs) * MUL_W'(US_PER_S);
    s1_q    <= s0_q;
    s2_cmd  <= s1_done;
  end

  assign cmd_push = s2_valid;
  assign cmd      = s2_cmd;

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> q_count < QCNT_W'(QDEPTH))
    else $error("command pushed into a full queue");

endmodule
`default_nettype wire

@@ hdl/epb_cmd_fifo.sv @@
`default_nettype none
module epb_cmd_fifo import epb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cmd_t              din,
  input  logic              pop,
  output cmd_t              dout,
  output logic              not_empty,
  output logic [QCNT_W-1:0] count
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  assign dout      = mem[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != QCNT_W'(QDEPTH))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("command queue underflow");

endmodule
`default_nettype wire

@@ hdl/epb_back.sv @@
`default_nettype none
module epb_back import epb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      head,
  output logic      cmd_pop,
  input  pos_t      pos,
  output logic      empty,
  input  logic      pop,
  output out_item_t framed
);

  back_phase_t       phase, phase_next;
  logic [STEP_W-1:0] idx, idx_next;
  logic [BLEN_W-1:0] cur_blen;
  opt_shape_t        cur_shape;
  logic              out_valid;

  logic              can_load;
  logic              emit;
  logic              latch;
  out_item_t         res;
  logic [STEP_W-1:0] last_idx;
  logic [31:0]       trail_word;
  logic              has_alt;

  function automatic logic [31:0] coord_offset(input logic signed [31:0] v);
    logic [31:0] r;
    if (v < COORD_MIN) begin
      r = 32'd0;
    end else if (v > COORD_MAX) begin
      r = COORD_SPAN;
    end else begin
      r = $unsigned(v) + $unsigned(COORD_MAX);
    end
    return r;
  endfunction

  assign can_load = !out_valid || pop;
  assign has_alt  = (cur_shape == OPT_GPS_ALT);

  always_comb begin
    case (cur_shape)
      OPT_GPS:     last_idx = TS_LAST_GPS;
      OPT_GPS_ALT: last_idx = TS_LAST_ALT;
      default:     last_idx = TS_OPT;
    endcase
  end

  // option words; the end-of-options word is zero
  always_comb begin
    case (idx)
      TS_OPT:   trail_word = {has_alt ? 16'd24 : 16'd20, OPT_CUSTOM};
      TS_PEN:   trail_word = GPS_PEN;
      TS_MAGIC: trail_word = {8'h00, has_alt ? 8'd12 : 8'd8, GPS_VER, MAGIC_TAG};
      TS_MASK:  trail_word = MASK_LON | MASK_LAT | (has_alt ? MASK_ALT : 32'd0);
      TS_LON:   trail_word = coord_offset(pos.longitude);
      TS_LAT:   trail_word = coord_offset(pos.latitude);
      TS_ALT:   trail_word = has_alt ? coord_offset(pos.altitude) : 32'd0;
      default:  trail_word = 32'd0;
    endcase
  end

  always_comb begin
    phase_next = phase;
    idx_next   = idx;
    emit       = 1'b0;
    cmd_pop    = 1'b0;
    latch      = 1'b0;
    res        = '0;
    unique case (phase)
      PH_CMD: begin
        if (cmd_valid && can_load) begin
          emit = 1'b1;
          unique case (head.kind)
            CMD_ERR: begin
              res.error = 1'b1;
              cmd_pop   = 1'b1;
            end
            CMD_WORD: begin
              res.word = head.data;
              cmd_pop  = 1'b1;
              if (head.trail) begin
                phase_next = PH_TRAIL;
                idx_next   = TS_OPT;
              end
            end
            CMD_HDR: begin
              case (idx)
                HS_TYPE:  res.word = EPB_TYPE;
                HS_BLEN:  res.word = 32'(head.blen);
                HS_IFACE: res.word = 32'd0;
                HS_TS_HI: res.word = 32'(head.ts[TS_W-1:32]);
                HS_TS_LO: res.word = head.ts[31:0];
                HS_CAP:   res.word = head.data;
                default:  res.word = head.orig;
              endcase
              if (idx == HS_TYPE) begin
                latch = 1'b1;
              end
              if (idx == HS_ORIG) begin
                cmd_pop  = 1'b1;
                idx_next = '0;
                if (head.trail) begin
                  phase_next = PH_TRAIL;
                end
              end else begin
                idx_next = idx + STEP_W'(1);
              end
            end
            default: begin
              emit    = 1'b0;
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      PH_TRAIL: begin
        if (can_load) begin
          emit = 1'b1;
          if (idx == last_idx) begin
            res.word   = 32'(cur_blen);
            res.last   = 1'b1;
            phase_next = PH_CMD;
            idx_next   = '0;
          end else begin
            res.word = trail_word;
            idx_next = idx + STEP_W'(1);
          end
        end
      end
      default: begin
        phase_next = PH_CMD;
        idx_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CMD;
      idx       <= '0;
      cur_shape <= OPT_NONE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      idx   <= idx_next;
      if (latch) begin
        cur_shape <= head.shape;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      cur_blen <= head.blen;
    end
    if (emit) begin
      framed <= res;
    end
  end

  assign empty = !out_valid;

  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    !empty && framed.error |-> framed.word == 32'd0 && !framed.last)
    else $error("error item carries data");

  a_trail_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TRAIL |-> idx <= last_idx)
    else $error("trailer step past block end");

endmodule
`default_nettype wire

@@ hdl/pcapng_epb_gps_framer.sv @@
`default_nettype none
// channel   dir   handshake           payload
// capture   in    push / full         in_item_t: op, timestamp, lengths, data_byte
// framed    out   pop / empty         out_item_t: word, last, error
// config    in    psel/penable (APB)  gps_enable, nano_mode, longitude, latitude, altitude
//
// one item is taken per cycle while full is low; a header goes through the timestamp pipe
// (divide by 1000 in nano mode, scale seconds, add) before it reaches the command queue.
// the back end emits one word per cycle unless the output stalls on pop: 7 per header,
// 1 per 4 data bytes, up to 9 for a trailer.
// full rises when queued plus in-flight commands reach 8; a stalled pop only holds
// the output register and the back end, the front keeps taking items until full rises.
// rst is synchronous and clears all control state.
module pcapng_epb_gps_framer import epb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  in_item_t          capture,
  output logic              empty,
  input  logic              pop,
  output out_item_t         framed,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic               gps_enable;
  logic               nano_mode;
  logic signed [31:0] longitude_e7;
  logic signed [31:0] latitude_e7;
  logic signed [31:0] altitude_e4;

  logic              cfg_wr;
  logic [2:0]        reg_idx;
  front_cfg_t        front_cfg;
  pos_t              pos;

  logic              cmd_push;
  cmd_t              cmd_in;
  cmd_t              cmd_head;
  logic              cmd_valid;
  logic              cmd_pop;
  logic [QCNT_W-1:0] q_count;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gps_enable   <= 1'b0;
      nano_mode    <= 1'b0;
      longitude_e7 <= '0;
      latitude_e7  <= '0;
      altitude_e4  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GPS_ENABLE:   gps_enable   <= pwdata[0];
        REG_NANO_MODE:    nano_mode    <= pwdata[0];
        REG_LONGITUDE_E7: longitude_e7 <= pwdata;
        REG_LATITUDE_E7:  latitude_e7  <= pwdata;
        REG_ALTITUDE_E4:  altitude_e4  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GPS_ENABLE:   prdata = 32'(gps_enable);
      REG_NANO_MODE:    prdata = 32'(nano_mode);
      REG_LONGITUDE_E7: prdata = longitude_e7;
      REG_LATITUDE_E7:  prdata = latitude_e7;
      REG_ALTITUDE_E4:  prdata = altitude_e4;
      default:          prdata = 32'd0;
    endcase
  end

  assign front_cfg.gps_enable  = gps_enable;
  assign front_cfg.nano_mode   = nano_mode;
  assign front_cfg.alt_present = (altitude_e4 != '0);

  assign pos.longitude = longitude_e7;
  assign pos.latitude  = latitude_e7;
  assign pos.altitude  = altitude_e4;

  epb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .capture  (capture),
    .cfg      (front_cfg),
    .q_count  (q_count),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  epb_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .din       (cmd_in),
    .pop       (cmd_pop),
    .dout      (cmd_head),
    .not_empty (cmd_valid),
    .count     (q_count)
  );

  epb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .head      (cmd_head),
    .cmd_pop   (cmd_pop),
    .pos       (pos),
    .empty     (empty),
    .pop       (pop),
    .framed    (framed)
  );

endmodule
`default_nettype wire
